/* design/pgs_pkg.sv */
// shared types, codes and helpers for the graymap stream parser
`default_nettype none

package pgs_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] value;
		logic [2:0]  error_code;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       eos;
		logic       is_digit;
		logic [3:0] digit;
		logic       is_ws;
		logic       is_eol;
		logic       is_hash;
		logic       is_p;
		logic       is_two;
		logic       is_five;
	} cls_t;

	localparam logic [2:0] K_WIDTH  = 3'd0;
	localparam logic [2:0] K_HEIGHT = 3'd1;
	localparam logic [2:0] K_MAXVAL = 3'd2;
	localparam logic [2:0] K_PIXEL  = 3'd3;
	localparam logic [2:0] K_ERROR  = 3'd4;

	localparam logic [2:0] E_NONE     = 3'd0;
	localparam logic [2:0] E_MAGIC    = 3'd0;
	localparam logic [2:0] E_TYPE     = 3'd1;
	localparam logic [2:0] E_DIGIT    = 3'd2;
	localparam logic [2:0] E_NO_SPACE = 3'd3;
	localparam logic [2:0] E_EARLY    = 3'd4;

	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_FIVE  = 8'h35;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;

	typedef enum logic [6:0] {
		PH_MAGIC  = 7'b0000001,
		PH_TYPE   = 7'b0000010,
		PH_WIDTH  = 7'b0000100,
		PH_HEIGHT = 7'b0001000,
		PH_MAXVAL = 7'b0010000,
		PH_PIXELS = 7'b0100000,
		PH_DONE   = 7'b1000000
	} phase_t;

	function automatic result_t mk_num(logic [2:0] kind, logic [31:0] value, logic last);
		result_t r;
		r.kind       = kind;
		r.value      = value;
		r.error_code = E_NONE;
		r.last       = last;
		return r;
	endfunction

	function automatic result_t mk_err(logic [2:0] code);
		result_t r;
		r.kind       = K_ERROR;
		r.value      = 32'd0;
		r.error_code = code;
		r.last       = 1'b1;
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/pgs_front.sv */
// front end: accepts stream words and classifies each byte
`default_nettype none

module pgs_front (
	input  var pgs_pkg::item_t item,
	input  wire                item_valid,
	output logic               item_ready,
	input  wire                queue_full,
	output logic               push,
	output pgs_pkg::cls_t      push_word
);
	import pgs_pkg::*;

	logic [7:0] b;

	assign b          = item.data_byte;
	assign item_ready = !queue_full;
	assign push       = item_valid && !queue_full;

	always_comb begin
		push_word.data_byte = b;
		push_word.eos       = item.end_of_stream;
		push_word.is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
		push_word.digit     = push_word.is_digit ? b[3:0] : 4'd0;
		push_word.is_ws     = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
		push_word.is_eol    = (b == CH_LF) || (b == CH_CR);
		push_word.is_hash   = (b == CH_HASH);
		push_word.is_p      = (b == CH_P);
		push_word.is_two    = (b == CH_TWO);
		push_word.is_five   = (b == CH_FIVE);
	end

endmodule

`default_nettype wire

/* design/pgs_queue.sv */
// two-entry queue between the classifier and the parser back end
`default_nettype none

module pgs_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  var pgs_pkg::cls_t  push_word,
	output logic               full,
	input  wire                pop,
	output pgs_pkg::cls_t      head,
	output logic               head_valid
);
	import pgs_pkg::*;

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	cls_t            mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [PW:0]     cnt_q;

	assign full       = (cnt_q == (PW+1)'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* design/pgs_back.sv */
// back end: parser state machine, pixel counters and result output stage
`default_nettype none

module pgs_back #(
	parameter int COUNT_BITS = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  var pgs_pkg::cls_t  head,
	input  wire                head_valid,
	output logic               pop,
	output pgs_pkg::result_t   result,
	output logic               result_valid,
	input  wire                result_ready
);
	import pgs_pkg::*;

	localparam int CB = COUNT_BITS;

	phase_t          ph_q, ph_d;
	logic            bin_q, bin_d;
	logic            cmt_q, cmt_d;
	logic [31:0]     acc_q, acc_d;
	logic            act_q, act_d;
	logic [CB-1:0]   w_q, w_d;
	logic [CB-1:0]   h_q, h_d;
	logic [CB-1:0]   col_q, col_d;
	logic [CB-1:0]   row_q, row_d;

	result_t         out_q, pend_q;
	logic            out_valid_q, pend_valid_q;

	result_t         r0, r1;
	logic [1:0]      nres;
	logic            out_free, can_take;
	logic [31:0]     acc_ten, dig32;
	logic            adv_last, fin, empty_img;
	logic [CB-1:0]   col_inc, adv_col, adv_row;

	assign out_free     = !out_valid_q || result_ready;
	assign can_take     = out_free && !pend_valid_q;
	assign pop          = head_valid && can_take;
	assign result       = out_q;
	assign result_valid = out_valid_q;

	assign dig32     = {28'd0, head.digit};
	assign acc_ten   = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + dig32;
	assign adv_last  = (col_q == (w_q - 1'b1)) && (row_q == (h_q - 1'b1));
	assign col_inc   = col_q + 1'b1;
	assign adv_col   = (col_inc == w_q) ? '0 : col_inc;
	assign adv_row   = (col_inc == w_q) ? row_q + 1'b1 : row_q;
	assign empty_img = (w_q == '0) || (h_q == '0);

	always_comb begin
		ph_d  = ph_q;
		bin_d = bin_q;
		cmt_d = cmt_q;
		acc_d = acc_q;
		act_d = act_q;
		w_d   = w_q;
		h_d   = h_q;
		col_d = col_q;
		row_d = row_q;
		nres  = 2'd0;
		r0    = mk_err(E_NONE);
		r1    = mk_err(E_NONE);
		fin   = 1'b0;
		if (head.eos) begin
			if (ph_q != PH_DONE && ph_q != PH_MAGIC) begin
				if (act_q) begin
					nres = 2'd1;
					unique case (ph_q)
						PH_PIXELS: begin
							fin = adv_last;
							r0  = mk_num(K_PIXEL, acc_q, adv_last);
						end
						PH_WIDTH:  r0 = mk_num(K_WIDTH, acc_q, 1'b0);
						PH_HEIGHT: r0 = mk_num(K_HEIGHT, acc_q, 1'b0);
						default:   r0 = mk_num(K_MAXVAL, acc_q, 1'b0);
					endcase
				end
				if (!fin) begin
					if (act_q) begin
						r1 = mk_err(E_EARLY);
					end else begin
						r0 = mk_err(E_EARLY);
					end
					nres = nres + 2'd1;
				end
			end
			ph_d  = PH_MAGIC;
			bin_d = 1'b0;
			cmt_d = 1'b0;
			acc_d = '0;
			act_d = 1'b0;
			w_d   = '0;
			h_d   = '0;
			col_d = '0;
			row_d = '0;
		end else begin
			unique case (ph_q)
				PH_MAGIC: begin
					if (head.is_p) begin
						ph_d = PH_TYPE;
					end else begin
						r0   = mk_err(E_MAGIC);
						nres = 2'd1;
						ph_d = PH_DONE;
					end
				end
				PH_TYPE: begin
					if (head.is_two || head.is_five) begin
						bin_d = head.is_five;
						ph_d  = PH_WIDTH;
					end else begin
						r0   = mk_err(E_TYPE);
						nres = 2'd1;
						ph_d = PH_DONE;
					end
				end
				PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
					if (cmt_q) begin
						if (head.is_eol) begin
							cmt_d = 1'b0;
						end
					end else if (act_q) begin
						if (head.is_digit) begin
							acc_d = acc_ten;
						end else begin
							act_d = 1'b0;
							nres  = 2'd1;
							if (ph_q == PH_MAXVAL) begin
								if (head.is_ws) begin
									r0    = mk_num(K_MAXVAL, acc_q, empty_img);
									col_d = '0;
									row_d = '0;
									ph_d  = empty_img ? PH_DONE : PH_PIXELS;
								end else begin
									r0   = mk_num(K_MAXVAL, acc_q, 1'b0);
									r1   = mk_err(E_NO_SPACE);
									nres = 2'd2;
									ph_d = PH_DONE;
								end
							end else begin
								if (ph_q == PH_WIDTH) begin
									w_d  = acc_q[CB-1:0];
									r0   = mk_num(K_WIDTH, acc_q, 1'b0);
									ph_d = PH_HEIGHT;
								end else begin
									h_d  = acc_q[CB-1:0];
									r0   = mk_num(K_HEIGHT, acc_q, 1'b0);
									ph_d = PH_MAXVAL;
								end
								if (head.is_hash) begin
									cmt_d = 1'b1;
								end else if (head.is_digit) begin
									acc_d = dig32;
									act_d = 1'b1;
								end else if (!head.is_ws) begin
									r1   = mk_err(E_DIGIT);
									nres = 2'd2;
									ph_d = PH_DONE;
								end
							end
						end
					end else begin
						if (head.is_hash) begin
							cmt_d = 1'b1;
						end else if (head.is_digit) begin
							acc_d = dig32;
							act_d = 1'b1;
						end else if (!head.is_ws) begin
							r0   = mk_err(E_DIGIT);
							nres = 2'd1;
							ph_d = PH_DONE;
						end
					end
				end
				PH_PIXELS: begin
					if (bin_q) begin
						r0    = mk_num(K_PIXEL, {24'd0, head.data_byte}, adv_last);
						nres  = 2'd1;
						col_d = adv_col;
						row_d = adv_row;
						if (adv_last) begin
							ph_d = PH_DONE;
						end
					end else if (act_q) begin
						if (head.is_digit) begin
							acc_d = acc_ten;
						end else begin
							act_d = 1'b0;
							col_d = adv_col;
							row_d = adv_row;
							r0    = mk_num(K_PIXEL, acc_q, adv_last);
							nres  = 2'd1;
							if (adv_last) begin
								ph_d = PH_DONE;
							end else if (!head.is_ws) begin
								r1   = mk_err(E_DIGIT);
								nres = 2'd2;
								ph_d = PH_DONE;
							end
						end
					end else if (head.is_digit) begin
						acc_d = dig32;
						act_d = 1'b1;
					end else if (!head.is_ws) begin
						r0   = mk_err(E_DIGIT);
						nres = 2'd1;
						ph_d = PH_DONE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_MAGIC;
			bin_q <= 1'b0;
			cmt_q <= 1'b0;
			acc_q <= '0;
			act_q <= 1'b0;
			w_q   <= '0;
			h_q   <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (pop) begin
			ph_q  <= ph_d;
			bin_q <= bin_d;
			cmt_q <= cmt_d;
			acc_q <= acc_d;
			act_q <= act_d;
			w_q   <= w_d;
			h_q   <= h_d;
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (out_free) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= pop && (nres != 2'd0);
				pend_valid_q <= pop && (nres == 2'd2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else begin
				out_q  <= r0;
				pend_q <= r1;
			end
		end
	end

endmodule

`default_nettype wire

/* design/pgm_stream_parser_top.sv */
// top level of the graymap (pgm) stream parser
// item channel: one stream word per handshake, a data byte or an end-of-stream
// mark. result channel: header numbers (width, height, maxval), pixels and
// numbered errors, with last set on the final result of an image.
// a word is classified on entry and written to a two-entry queue; the parser
// back end takes one word per cycle from the queue, while the holding stage is
// empty and the result register is free or being read, and drives a result
// register with a one-result holding stage behind it. a word is stored in the
// queue, and its result in the result register. a word with two results
// (number then error) holds the back end until the holding stage drains.
// when the receiver stalls, the output stage and queue fill and item_ready
// drops once the queue is full; no result is lost or repeated.
// reset clears the parser to wait for the 'P' of a new image and empties the
// queue and output stage. end_of_stream closes any pending number, reports
// an early end if the image is incomplete, and rearms the parser.
// COUNT_BITS sets the width of the pixel column and row counters.
`default_nettype none

module pgm_stream_parser_top #(
	parameter int COUNT_BITS = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  var pgs_pkg::item_t  item,
	input  wire                 item_valid,
	output logic                item_ready,
	output pgs_pkg::result_t    result,
	output logic                result_valid,
	input  wire                 result_ready
);
	import pgs_pkg::*;

	logic  q_full, q_push, q_pop, q_head_valid;
	cls_t  q_push_word, q_head;

	pgs_front u_front (
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.queue_full (q_full),
		.push       (q_push),
		.push_word  (q_push_word)
	);

	pgs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_word  (q_push_word),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.head_valid (q_head_valid)
	);

	pgs_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.head_valid   (q_head_valid),
		.pop          (q_pop),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule

`default_nettype wire

/* sim/testbench.sv */
// self-checking testbench for the graymap stream parser, with a bit-exact parse model
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pgs_pkg::*;

	localparam int COUNT_BITS = 32;
	localparam int RANDOM_WORDS = 2000;
	localparam int STALL_CYCLES = 300;
	localparam int CYCLE_LIMIT = 500000;
	localparam int TAIL_CYCLES = 20;

	class graymap_parse;
		phase_t      phase;
		bit          raw_mode;
		bit          in_comment;
		bit          num_open;
		logic [31:0] num;
		logic [31:0] width;
		logic [31:0] height;
		logic [31:0] col;
		logic [31:0] row;
		logic [31:0] cmask;
		result_t     pending_results[$];
		int          mismatches;

		function new(int count_bits);
			cmask = (count_bits >= 32) ? 32'hffff_ffff : 32'((64'd1 << count_bits) - 64'd1);
			mismatches = 0;
			rearm();
		endfunction

		function void rearm();
			phase = PH_MAGIC;
			raw_mode = 1'b0;
			in_comment = 1'b0;
			num_open = 1'b0;
			num = '0;
			width = '0;
			height = '0;
			col = '0;
			row = '0;
		endfunction

		function bit is_space(logic [7:0] b);
			return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
		endfunction

		function bit is_digit(logic [7:0] b);
			return b >= CH_ZERO && b <= CH_NINE;
		endfunction

		function logic [31:0] digit_of(logic [7:0] b);
			return 32'(b - CH_ZERO);
		endfunction

		function void push(logic [2:0] kind, logic [31:0] value, logic [2:0] code, logic last);
			result_t r;
			r.kind = kind;
			r.value = value;
			r.error_code = code;
			r.last = last;
			pending_results.push_back(r);
		endfunction

		function void fail(logic [2:0] code);
			push(K_ERROR, 32'd0, code, 1'b1);
			phase = PH_DONE;
		endfunction

		function bit next_pixel();
			logic [31:0] w;
			logic [31:0] h;
			bit          fin;
			w = width & cmask;
			h = height & cmask;
			fin = (col == ((w - 32'd1) & cmask)) && (row == ((h - 32'd1) & cmask));
			col = (col + 32'd1) & cmask;
			if (col == w) begin
				col = '0;
				row = (row + 32'd1) & cmask;
			end
			return fin;
		endfunction

		function void gap(logic [7:0] b);
			if (is_space(b))
				return;
			if (b == CH_HASH) begin
				in_comment = 1'b1;
			end else if (is_digit(b)) begin
				num = digit_of(b);
				num_open = 1'b1;
			end else begin
				fail(E_DIGIT);
			end
		endfunction

		function void take_word(item_t w);
			logic [7:0] b;
			bit         fin;
			bit         empty;
			b = w.data_byte;
			fin = 1'b0;
			if (w.end_of_stream) begin
				if (phase != PH_DONE && phase != PH_MAGIC) begin
					if (num_open) begin
						case (phase)
							PH_PIXELS: begin
								fin = next_pixel();
								push(K_PIXEL, num, E_NONE, fin);
							end
							PH_WIDTH:  push(K_WIDTH, num, E_NONE, 1'b0);
							PH_HEIGHT: push(K_HEIGHT, num, E_NONE, 1'b0);
							PH_MAXVAL: push(K_MAXVAL, num, E_NONE, 1'b0);
							default: ;
						endcase
					end
					if (!fin)
						push(K_ERROR, 32'd0, E_EARLY, 1'b1);
				end
				rearm();
				return;
			end
			case (phase)
				PH_MAGIC: begin
					if (b == CH_P)
						phase = PH_TYPE;
					else
						fail(E_MAGIC);
				end
				PH_TYPE: begin
					if (b == CH_TWO) begin
						raw_mode = 1'b0;
						phase = PH_WIDTH;
					end else if (b == CH_FIVE) begin
						raw_mode = 1'b1;
						phase = PH_WIDTH;
					end else begin
						fail(E_TYPE);
					end
				end
				PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
					if (in_comment) begin
						if (b == CH_LF || b == CH_CR)
							in_comment = 1'b0;
					end else if (num_open) begin
						if (is_digit(b)) begin
							num = num * 32'd10 + digit_of(b);
						end else begin
							num_open = 1'b0;
							if (phase == PH_MAXVAL) begin
								if (is_space(b)) begin
									empty = (width & cmask) == '0 || (height & cmask) == '0;
									push(K_MAXVAL, num, E_NONE, empty);
									col = '0;
									row = '0;
									phase = empty ? PH_DONE : PH_PIXELS;
								end else begin
									push(K_MAXVAL, num, E_NONE, 1'b0);
									fail(E_NO_SPACE);
								end
							end else begin
								if (phase == PH_WIDTH) begin
									width = num;
									push(K_WIDTH, num, E_NONE, 1'b0);
									phase = PH_HEIGHT;
								end else begin
									height = num;
									push(K_HEIGHT, num, E_NONE, 1'b0);
									phase = PH_MAXVAL;
								end
								gap(b);
							end
						end
					end else begin
						gap(b);
					end
				end
				PH_PIXELS: begin
					if (raw_mode) begin
						fin = next_pixel();
						push(K_PIXEL, {24'd0, b}, E_NONE, fin);
						if (fin)
							phase = PH_DONE;
					end else if (num_open) begin
						if (is_digit(b)) begin
							num = num * 32'd10 + digit_of(b);
						end else begin
							fin = next_pixel();
							num_open = 1'b0;
							push(K_PIXEL, num, E_NONE, fin);
							if (fin)
								phase = PH_DONE;
							else if (!is_space(b))
								fail(E_DIGIT);
						end
					end else if (is_digit(b)) begin
						num = digit_of(b);
						num_open = 1'b1;
					end else if (!is_space(b)) begin
						fail(E_DIGIT);
					end
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		task check_result(result_t r);
			result_t e;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result kind %0d value %0d code %0d last %0d",
					r.kind, r.value, r.error_code, r.last));
				return;
			end
			e = pending_results.pop_front();
			if (r.kind != e.kind)
				report($sformatf("kind %0d, expected %0d", r.kind, e.kind));
			if (r.value != e.value)
				report($sformatf("value %0d, expected %0d (kind %0d)", r.value, e.value, e.kind));
			if (r.error_code != e.error_code)
				report($sformatf("error_code %0d, expected %0d", r.error_code, e.error_code));
			if (r.last != e.last)
				report($sformatf("last %0d, expected %0d (kind %0d)", r.last, e.last, e.kind));
		endtask
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	item_t   item = '0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	result_t result;
	logic    result_valid;
	logic    result_ready = 1'b0;

	int send_idle = 0;
	int recv_idle = 0;
	int words_sent = 0;
	int cycles = 0;
	int stall_left = 0;
	bit stall_req = 1'b0;
	bit stall_taken = 1'b0;

	logic [7:0]   stream_q[$];
	graymap_parse graymap;

	pgm_stream_parser_top #(
		.COUNT_BITS(COUNT_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.result(result),
		.result_valid(result_valid),
		.result_ready(result_ready)
	);

	always #10 clk = ~clk;

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** pgm_stream_parser_top: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left <= stall_left - 1;
		else if (stall_req && !stall_taken) begin
			stall_left <= STALL_CYCLES;
			stall_taken <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0)
			result_ready <= 1'b0;
		else
			result_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				graymap.take_word(item);
			if (result_valid && result_ready)
				graymap.check_result(result);
		end
	end

	task automatic send_word(input logic [7:0] b, input logic eos);
		item_t w;
		w.data_byte = b;
		w.end_of_stream = eos;
		if ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		item <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		words_sent++;
	endtask

	task automatic send_eos();
		send_word(8'($urandom), 1'b1);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], 1'b0);
	endtask

	task automatic send_stream();
		foreach (stream_q[i])
			send_word(stream_q[i], 1'b0);
		stream_q.delete();
	endtask

	function automatic logic [7:0] space_byte();
		int k;
		k = $urandom_range(5);
		return (k == 0) ? CH_SPACE : 8'(8 + k);
	endfunction

	function automatic logic [7:0] comment_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == CH_LF || b == CH_CR);
		return b;
	endfunction

	function automatic void put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			stream_q.push_back(s[i]);
	endfunction

	function automatic void put_number(input logic [31:0] v);
		logic [7:0] d[$];
		if ($urandom_range(9) == 0)
			stream_q.push_back(CH_ZERO);
		do begin
			d.push_front(CH_ZERO + 8'(v % 32'd10));
			v = v / 32'd10;
		end while (v != '0);
		foreach (d[i])
			stream_q.push_back(d[i]);
	endfunction

	function automatic void put_digits(input int n);
		repeat (n)
			stream_q.push_back(CH_ZERO + 8'($urandom_range(9)));
	endfunction

	function automatic void put_gap(input bit need);
		int n;
		n = need ? $urandom_range(1, 3) : $urandom_range(0, 2);
		repeat (n) begin
			if ($urandom_range(4) == 0) begin
				stream_q.push_back(CH_HASH);
				repeat ($urandom_range(4))
					stream_q.push_back(comment_byte());
				stream_q.push_back($urandom_range(1) ? CH_LF : CH_CR);
			end else begin
				stream_q.push_back(space_byte());
			end
		end
	endfunction

	task automatic random_image(input bit mangle);
		bit raw;
		int w;
		int h;
		int npix;
		int cut;
		raw = 1'($urandom_range(1));
		w = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(5);
		h = (w > 5) ? 1 : $urandom_range(4);
		stream_q.delete();
		put_text(raw ? "P5" : "P2");
		put_gap(1'b0);
		if ($urandom_range(29) == 0) begin
			put_text("4294967296");
			w = 0;
		end else begin
			put_number(32'(w));
		end
		put_gap(1'b1);
		put_number(32'(h));
		put_gap(1'b1);
		case ($urandom_range(9))
			0: put_digits($urandom_range(10, 14));
			1: put_number(32'hffff_ffff);
			default: put_number(32'($urandom_range(255)));
		endcase
		stream_q.push_back(space_byte());
		npix = w * h;
		for (int i = 0; i < npix; i++) begin
			if (raw) begin
				stream_q.push_back(8'($urandom));
			end else begin
				if ($urandom_range(19) == 0)
					put_digits($urandom_range(1, 12));
				else
					put_number(32'($urandom_range(300)));
				if (i < npix - 1) begin
					stream_q.push_back(space_byte());
					if ($urandom_range(3) == 0)
						stream_q.push_back(space_byte());
				end else begin
					stream_q.push_back(8'($urandom));
				end
			end
		end
		repeat ($urandom_range(3))
			stream_q.push_back(8'($urandom));
		if (mangle) begin
			case ($urandom_range(9))
				0: stream_q[$urandom_range(stream_q.size() - 1)] = 8'($urandom);
				1: begin
					cut = $urandom_range(stream_q.size() - 1);
					while (stream_q.size() > cut)
						void'(stream_q.pop_back());
				end
				default: ;
			endcase
		end
		send_stream();
		send_eos();
	endtask

	task automatic random_noise();
		stream_q.delete();
		if ($urandom_range(1))
			stream_q.push_back(CH_P);
		repeat ($urandom_range(1, 6))
			stream_q.push_back(8'($urandom));
		send_stream();
		send_eos();
	endtask

	initial begin
		int goal;
		int k;
		graymap = new(COUNT_BITS);
		wait (arst_n);
		@(posedge clk);

		// short directed run over the header, pixel and error paths
		send_eos();
		send_word(8'h00, 1'b0);
		send_eos();
		send_text("P7");
		send_eos();
		send_text("P50 1 9\n");
		send_eos();
		send_text("P21#\n1 7x");
		send_eos();
		send_text("P51 1 9 ");
		send_word(8'hff, 1'b0);
		send_eos();
		send_text("P22 1 9 3 45");
		send_eos();
		send_text("P22 1 9 3x");
		send_eos();
		send_text("P2!");
		send_eos();
		send_text("P2 12");
		send_eos();

		for (int p = 0; p < 3; p++) begin
			send_idle = (p == 0) ? 11 : (p == 1) ? 75 : 0;
			recv_idle = (p == 0) ? 75 : (p == 1) ? 11 : 0;
			goal = words_sent + RANDOM_WORDS / 3;
			if (p == 2) begin
				// receiver holds off as a full raw image is offered, so back-pressure stalls the sender
				stall_req <= 1'b1;
				stream_q.delete();
				put_text("P5 8 8 255\n");
				repeat (64)
					stream_q.push_back(8'($urandom));
				send_stream();
				send_eos();
			end
			while (words_sent < goal) begin
				k = $urandom_range(19);
				if (k < 15)
					random_image(1'b1);
				else if (k < 19)
					random_noise();
				else
					send_eos();
			end
		end

		item_valid <= 1'b0;
		@(posedge clk);
		while (graymap.pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (graymap.mismatches == 0 && graymap.pending_results.size() == 0)
			$display("** pgm_stream_parser_top: PASSED **");
		else
			$display("** pgm_stream_parser_top: FAILED **");
		$finish;
	end
endmodule

/* pgm_stream_parser_top.f */
design/pgs_pkg.sv
design/pgs_front.sv
design/pgs_queue.sv
design/pgs_back.sv
design/pgm_stream_parser_top.sv
sim/testbench.sv
